>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ectc_pkg.sv
// Types, character codes and helpers of the colour text console
package ectc_pkg;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_FG      = 8'h33;
    localparam logic [7:0] CH_BG      = 8'h34;
    localparam logic [7:0] CH_RESET   = 8'h30;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] FIRST_GLYPH = 8'd32;

    localparam logic [2:0] PAL_WHITE = 3'd7;
    localparam logic [2:0] PAL_BLACK = 3'd0;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd30;

    localparam logic [7:0] REG_TEXT_COLUMNS = 8'd0;
    localparam logic [7:0] REG_TEXT_ROWS    = 8'd1;

    typedef enum logic [6:0] {
        PH_NORMAL   = 7'b0000001,
        PH_ESC      = 7'b0000010,
        PH_BRACKET  = 7'b0000100,
        PH_FG_DIGIT = 7'b0001000,
        PH_BG_DIGIT = 7'b0010000,
        PH_SKIP     = 7'b0100000,
        PH_FORCE    = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_NEWLINE = 2'd1,
        ACT_GLYPH   = 2'd2
    } t_act;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] fg;
        logic [2:0] bg;
        t_act       act;
    } t_parse_out;

    // Ids 1 to 7 keep their value, anything else is black
    function automatic logic [2:0] color_of_id(input logic [7:0] b);
        logic [7:0] id;
        id = b - CH_DIGIT0;
        return (id >= 8'd1 && id <= 8'd7) ? id[2:0] : PAL_BLACK;
    endfunction

endpackage

>>> hw/rtl/escape_color_text_console_core.sv
// Colour text console top level: byte parser, cursor and glyph column sequencer
//
// Input channel (i_valid / o_stall) carries one transaction per byte or font
// write: i_mode 0 interprets i_char_byte, i_mode 1 stores i_font_word at
// i_font_addr. Output channel (o_valid / i_stall) delivers one transaction
// per glyph column with its pixel position, column bits and colours;
// o_last marks the final column of a glyph.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
// text_columns (index 0) and text_rows (index 1); other indexes are ignored.
// Font writes, escape bytes, zero bytes and newlines give no output. A
// printable byte is taken, then the input stays stalled until the last
// column of its glyph is loaded into the output register. One font memory
// read per column is addressed by the glyph base plus the column counter;
// the byte is taken, the column is read, then the output register is
// loaded. A stall on the output holds the output register and the
// pending read. Reset puts the parser in plain text, the cursor at the top
// left, colours white on black and the geometry at 80 by 30; the font
// store has no reset and must be written before use.
`include "assert_macros.svh"

module escape_color_text_console_core #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_COUNT  = 96
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_char_byte,
    input  logic [9:0]  i_font_addr,
    input  logic [15:0] i_font_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_pix_x,
    output logic [11:0] o_pix_y,
    output logic [15:0] o_column_bits,
    output logic [2:0]  o_fg_index,
    output logic [2:0]  o_bg_index,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
    localparam int AW  = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
    localparam int CNW = $clog2(GLYPH_WIDTH + 1);
    localparam int QW  = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam logic [16:0] HMASK17 = (17'd1 << GLYPH_HEIGHT) - 17'd1;
    localparam logic [15:0] HMASK   = HMASK17[15:0];
    localparam logic [8:0]  GCOUNT9 = 9'(GLYPH_COUNT);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DRAW = 2'b10
    } t_state;

    t_state              r_state, n_state;
    ectc_pkg::t_phase    r_phase;
    logic [2:0]          r_fg, r_bg;
    logic [7:0]          r_cur_col, r_cur_row, n_cur_col, n_cur_row;
    logic [7:0]          r_cols, r_rows;
    logic [CNW-1:0]      r_col;
    logic                r_qv;
    logic [QW-1:0]       r_qcol;
    logic                r_ovalid;
    logic                r_gvalid;
    logic [AW-1:0]       r_gbase;
    logic [11:0]         r_base_x, r_base_y;

    ectc_pkg::t_parse_out parse;
    logic        in_acc, txt_acc, font_acc, font_we;
    logic        out_free, load_out, rd_en, start_glyph;
    logic [7:0]  glyph_idx;
    logic        glyph_ok;
    logic [8:0]  adv_row_sum;
    logic [7:0]  adv_row;
    logic [AW-1:0] rd_addr;
    logic [15:0] rd_data;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign txt_acc     = in_acc && !i_mode;
    assign font_acc    = in_acc && i_mode;
    assign font_we     = font_acc && (32'(i_font_addr) < 32'(FONT_DEPTH));

    ectc_parser u_parser (
        .i_phase (r_phase),
        .i_byte  (i_char_byte),
        .i_fg    (r_fg),
        .i_bg    (r_bg),
        .o_res   (parse)
    );

    assign glyph_idx   = i_char_byte - ectc_pkg::FIRST_GLYPH;
    assign glyph_ok    = (i_char_byte >= ectc_pkg::FIRST_GLYPH)
                         && ({1'b0, glyph_idx} < GCOUNT9);
    assign start_glyph = txt_acc && (parse.act == ectc_pkg::ACT_GLYPH);

    // row advance stops at the last row
    assign adv_row_sum = {1'b0, r_cur_row} + 9'd1;
    assign adv_row     = (adv_row_sum < {1'b0, r_rows}) ? adv_row_sum[7:0] : r_cur_row;

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (txt_acc && parse.act == ectc_pkg::ACT_NEWLINE) begin
            n_cur_col = 8'd0;
            n_cur_row = adv_row;
        end else if (start_glyph) begin
            if (({1'b0, r_cur_col} + 9'd1) >= {1'b0, r_cols}) begin
                n_cur_col = 8'd0;
                n_cur_row = adv_row;
            end else begin
                n_cur_col = r_cur_col + 8'd1;
            end
        end
    end

    // column sequencer: one read in flight, hold it while the output is blocked
    assign out_free = !r_ovalid || !i_stall;
    assign load_out = (r_state == S_DRAW) && r_qv && out_free;
    assign rd_en    = (r_state == S_DRAW) && (r_col < CNW'(GLYPH_WIDTH))
                      && (!r_qv || load_out);
    assign rd_addr  = r_gbase + AW'(r_col);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start_glyph) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (load_out && r_qcol == QW'(GLYPH_WIDTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    ectc_font_ram #(
        .DEPTH (FONT_DEPTH),
        .AW    (AW)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (AW'(i_font_addr)),
        .i_wdata (i_font_word & HMASK),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= ectc_pkg::PH_NORMAL;
            r_fg      <= ectc_pkg::PAL_WHITE;
            r_bg      <= ectc_pkg::PAL_BLACK;
            r_cur_col <= 8'd0;
            r_cur_row <= 8'd0;
            r_cols    <= ectc_pkg::COLS_RESET;
            r_rows    <= ectc_pkg::ROWS_RESET;
            r_col     <= '0;
            r_qv      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            if (txt_acc) begin
                r_phase <= parse.phase;
                r_fg    <= parse.fg;
                r_bg    <= parse.bg;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ectc_pkg::REG_TEXT_COLUMNS) begin
                    r_cols <= i_cfg_data;
                end else if (i_cfg_index == ectc_pkg::REG_TEXT_ROWS) begin
                    r_rows <= i_cfg_data;
                end
            end
            if (start_glyph) begin
                r_col <= '0;
            end else if (rd_en) begin
                r_col <= r_col + CNW'(1);
            end
            if (rd_en) begin
                r_qv <= 1'b1;
            end else if (load_out) begin
                r_qv <= 1'b0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // glyph snapshot and output payload
    always_ff @(posedge i_clk) begin
        if (start_glyph) begin
            r_gvalid <= glyph_ok;
            r_gbase  <= glyph_ok ? AW'(32'(glyph_idx) * GLYPH_WIDTH) : '0;
            r_base_x <= 12'(32'(r_cur_col) * GLYPH_WIDTH);
            r_base_y <= 12'(32'(r_cur_row) * GLYPH_HEIGHT);
        end
        if (rd_en) begin
            r_qcol <= QW'(r_col);
        end
        if (load_out) begin
            o_pix_x       <= r_base_x + 12'(r_qcol);
            o_pix_y       <= r_base_y;
            o_column_bits <= r_gvalid ? rd_data : 16'd0;
            o_fg_index    <= r_fg;
            o_bg_index    <= r_bg;
            o_last        <= (r_qcol == QW'(GLYPH_WIDTH - 1));
        end
    end

    assign o_valid = r_ovalid;

    `ASSERT_IMPL(a_idle_no_pending, i_clk, i_rst_n, r_state == S_IDLE, !r_qv,
                 "read pending while idle")
    `ASSERT_NEXT(a_last_ends_glyph, i_clk, i_rst_n, load_out && r_qcol == QW'(GLYPH_WIDTH - 1),
                 r_state == S_IDLE && o_valid && o_last, "last column did not end glyph")
    `ASSERT_IMPL(a_col_bound, i_clk, i_rst_n, r_state == S_DRAW, r_col <= CNW'(GLYPH_WIDTH),
                 "column counter past glyph width")

endmodule

>>> hw/rtl/ectc_font_ram.sv
// Glyph column store: one write port, one registered read port
module ectc_font_ram #(
    parameter int DEPTH = 768,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ectc_parser.sv
// Escape grammar decoder: next parser phase, colours and cursor action for one byte
module ectc_parser (
    input  ectc_pkg::t_phase     i_phase,
    input  logic [7:0]           i_byte,
    input  logic [2:0]           i_fg,
    input  logic [2:0]           i_bg,
    output ectc_pkg::t_parse_out o_res
);

    ectc_pkg::t_act emit_act;

    assign emit_act = (i_byte == ectc_pkg::CH_NEWLINE) ? ectc_pkg::ACT_NEWLINE
                                                       : ectc_pkg::ACT_GLYPH;

    always_comb begin
        o_res.phase = i_phase;
        o_res.fg    = i_fg;
        o_res.bg    = i_bg;
        o_res.act   = ectc_pkg::ACT_NONE;
        if (i_byte == ectc_pkg::CH_NUL) begin
            o_res.phase = ectc_pkg::PH_NORMAL;
        end else begin
            case (i_phase)
                ectc_pkg::PH_NORMAL: begin
                    if (i_byte == ectc_pkg::CH_ESC) begin
                        o_res.phase = ectc_pkg::PH_ESC;
                    end else begin
                        o_res.act = emit_act;
                    end
                end
                ectc_pkg::PH_ESC: begin
                    if (i_byte == ectc_pkg::CH_BRACKET) begin
                        o_res.phase = ectc_pkg::PH_BRACKET;
                    end else begin
                        o_res.phase = ectc_pkg::PH_NORMAL;
                        o_res.act   = emit_act;
                    end
                end
                ectc_pkg::PH_BRACKET: begin
                    if (i_byte == ectc_pkg::CH_FG) begin
                        o_res.phase = ectc_pkg::PH_FG_DIGIT;
                    end else if (i_byte == ectc_pkg::CH_BG) begin
                        o_res.phase = ectc_pkg::PH_BG_DIGIT;
                    end else begin
                        if (i_byte == ectc_pkg::CH_RESET) begin
                            o_res.fg = ectc_pkg::PAL_WHITE;
                            o_res.bg = ectc_pkg::PAL_BLACK;
                        end
                        o_res.phase = ectc_pkg::PH_SKIP;
                    end
                end
                ectc_pkg::PH_FG_DIGIT: begin
                    o_res.fg    = ectc_pkg::color_of_id(i_byte);
                    o_res.phase = ectc_pkg::PH_SKIP;
                end
                ectc_pkg::PH_BG_DIGIT: begin
                    o_res.bg    = ectc_pkg::color_of_id(i_byte);
                    o_res.phase = ectc_pkg::PH_SKIP;
                end
                ectc_pkg::PH_SKIP: begin
                    o_res.phase = ectc_pkg::PH_FORCE;
                end
                default: begin
                    // forced byte: print without parsing
                    o_res.phase = ectc_pkg::PH_NORMAL;
                    o_res.act   = emit_act;
                end
            endcase
        end
    end

endmodule
